[rtl/hpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared widths and types of the homogeneous point projector.
// ----------------------------------------------------------------------------
package hpp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int COEF_W      = 32;
	localparam int NUM_REGS    = 6;
	localparam int REG_W       = 2 * COEF_W;
	localparam int IDX_W       = 3;

	// Exact product and dot-product widths
	localparam int PROD_W = COEF_W + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int DIV_W  = MAG_W + COORD_WIDTH;
	localparam int CMP_W  = (NUM_W > DIV_W) ? NUM_W : DIV_W;

	// Pipeline stages: two dot-product stages, setup, one stage per quotient bit, output
	localparam int DIV_LAT  = COORD_WIDTH + 2;
	localparam int PIPE_LAT = DIV_LAT + 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_ROW0_C01 = 3'd0;
	localparam logic [IDX_W-1:0] REG_ROW0_C23 = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROW1_C01 = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROW1_C23 = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROW2_C01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROW2_C23 = 3'd5;

	localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'd1 << FRAC_BITS);
	localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'd1 << FRAC_BITS) << COEF_W;

	typedef logic signed [COEF_W-1:0]      coef_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [SUM_W-1:0]       dot_t;
	typedef coef_t                          coef_row_t [4];

endpackage

[rtl/hpp_dot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_dot
// Two-stage dot product of the three matrix rows with [x, y, z, 1].
// ----------------------------------------------------------------------------
module hpp_dot (
	input  logic              clk,
	input  logic              en,
	input  hpp_pkg::coef_row_t row0,
	input  hpp_pkg::coef_row_t row1,
	input  hpp_pkg::coef_row_t row2,
	input  hpp_pkg::coord_t   x,
	input  hpp_pkg::coord_t   y,
	input  hpp_pkg::coord_t   z,
	output hpp_pkg::dot_t     a,
	output hpp_pkg::dot_t     b,
	output hpp_pkg::dot_t     w
);
	import hpp_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [3][3];
	coef_t                    c3_s1 [3];
	dot_t                     sum_s2 [3];
	coef_t                    rows [3][4];

	always_comb begin
		rows[0] = row0;
		rows[1] = row1;
		rows[2] = row2;
	end

	// Stage 1: register the nine coefficient by coordinate products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= PROD_W'(rows[r][0]) * PROD_W'(x);
				prod_s1[r][1] <= PROD_W'(rows[r][1]) * PROD_W'(y);
				prod_s1[r][2] <= PROD_W'(rows[r][2]) * PROD_W'(z);
				c3_s1[r]      <= rows[r][3];
			end
		end
	end

	// Stage 2: add the products and the scaled translation column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
					+ SUM_W'(prod_s1[r][2]) + (SUM_W'(c3_s1[r]) <<< FRAC_BITS);
			end
		end
	end

	assign a = sum_s2[0];
	assign b = sum_s2[1];
	assign w = sum_s2[2];

endmodule

[rtl/hpp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_div
// Pipelined signed divide (num << FRAC_BITS) / den, truncated, saturated.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
module hpp_div (
	input  logic            clk,
	input  logic            en,
	input  hpp_pkg::dot_t   num,
	input  hpp_pkg::dot_t   den,
	output hpp_pkg::coord_t quo,
	output logic            sat
);
	import hpp_pkg::*;

	logic [NUM_W-1:0]       rem_st [0:COORD_WIDTH];
	logic [COORD_WIDTH-1:0] q_st   [0:COORD_WIDTH];
	logic [MAG_W-1:0]       d_st   [0:COORD_WIDTH];
	logic                   neg_st [0:COORD_WIDTH];
	logic                   ovf_st [0:COORD_WIDTH];

	logic [MAG_W-1:0]       n_mag, d_mag;
	logic [NUM_W-1:0]       n_shift;
	logic                   n_ovf;
	logic [COORD_WIDTH-1:0] limit, q_last;
	logic                   clamp;
	coord_t                 quo_q;
	logic                   sat_q;

	// Magnitudes and the quotient overflow test
	always_comb begin
		n_mag   = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
		d_mag   = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
		n_shift = NUM_W'(n_mag) << FRAC_BITS;
		n_ovf   = CMP_W'(n_shift) >= (CMP_W'(d_mag) << COORD_WIDTH);
	end

	// Setup stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_st[0] <= n_shift;
			q_st[0]   <= '0;
			d_st[0]   <= d_mag;
			neg_st[0] <= num[SUM_W-1] ^ den[SUM_W-1];
			ovf_st[0] <= n_ovf;
		end
	end

	// Restoring division, most significant quotient bit first
	for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_bit
		logic [CMP_W-1:0] rz, tr, df;
		logic             ge;

		always_comb begin
			rz = CMP_W'(rem_st[i]);
			tr = CMP_W'(d_st[i]) << (COORD_WIDTH - 1 - i);
			ge = rz >= tr;
			df = rz - tr;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_st[i+1] <= ge ? NUM_W'(df) : rem_st[i];
				q_st[i+1]   <= {q_st[i][COORD_WIDTH-2:0], ge};
				d_st[i+1]   <= d_st[i];
				neg_st[i+1] <= neg_st[i];
				ovf_st[i+1] <= ovf_st[i];
			end
		end
	end

	// Clamp to the signed range and apply the sign
	always_comb begin
		q_last = q_st[COORD_WIDTH];
		limit  = neg_st[COORD_WIDTH] ? (COORD_WIDTH'(1) << (COORD_WIDTH - 1))
			: ((COORD_WIDTH'(1) << (COORD_WIDTH - 1)) - COORD_WIDTH'(1));
		clamp  = ovf_st[COORD_WIDTH] || (q_last > limit);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q <= clamp;
			if (neg_st[COORD_WIDTH])
				quo_q <= -(clamp ? limit : q_last);
			else
				quo_q <= clamp ? limit : q_last;
		end
	end

	assign quo = quo_q;
	assign sat = sat_q;

endmodule

[rtl/homogeneous_point_projector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_point_projector_unit
// Projects a world point through a 3x4 matrix and divides by the depth.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | world_x, world_y, world_z
//  out     | output    | out_valid/out_stall| pixel_u, pixel_v, zero_depth, saturated
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while no result is held. An item passes 36 register stages
// (two dot-product, one divider setup, 32 quotient-bit stages in each of the two
// divider lanes, one output).
// Reset clears the valid bits and loads the matrix with [I|0].
// A stalled result holds the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module homogeneous_point_projector_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [hpp_pkg::COORD_WIDTH-1:0] world_x,
	input  logic signed [hpp_pkg::COORD_WIDTH-1:0] world_y,
	input  logic signed [hpp_pkg::COORD_WIDTH-1:0] world_z,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [hpp_pkg::COORD_WIDTH-1:0] pixel_u,
	output logic signed [hpp_pkg::COORD_WIDTH-1:0] pixel_v,
	output logic                            zero_depth,
	output logic                            saturated,
	input  logic                            cfg_we,
	input  logic [hpp_pkg::IDX_W-1:0]       cfg_index,
	input  logic [hpp_pkg::REG_W-1:0]       cfg_data
);
	import hpp_pkg::*;

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic             vld_q  [PIPE_LAT];
	logic             zero_q [DIV_LAT];
	logic             adv;
	coef_row_t        row0, row1, row2;
	dot_t             a, b, w;
	coord_t           u_q, v_q;
	logic             su, sv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_ROW0_C01] <= ONE_LO;
			regs_q[REG_ROW0_C23] <= '0;
			regs_q[REG_ROW1_C01] <= ONE_HI;
			regs_q[REG_ROW1_C23] <= '0;
			regs_q[REG_ROW2_C01] <= '0;
			regs_q[REG_ROW2_C23] <= ONE_LO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0_C01: regs_q[REG_ROW0_C01] <= cfg_data;
				REG_ROW0_C23: regs_q[REG_ROW0_C23] <= cfg_data;
				REG_ROW1_C01: regs_q[REG_ROW1_C01] <= cfg_data;
				REG_ROW1_C23: regs_q[REG_ROW1_C23] <= cfg_data;
				REG_ROW2_C01: regs_q[REG_ROW2_C01] <= cfg_data;
				REG_ROW2_C23: regs_q[REG_ROW2_C23] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack coefficient halves
	always_comb begin
		row0[0] = regs_q[REG_ROW0_C01][COEF_W-1:0];
		row0[1] = regs_q[REG_ROW0_C01][REG_W-1:COEF_W];
		row0[2] = regs_q[REG_ROW0_C23][COEF_W-1:0];
		row0[3] = regs_q[REG_ROW0_C23][REG_W-1:COEF_W];
		row1[0] = regs_q[REG_ROW1_C01][COEF_W-1:0];
		row1[1] = regs_q[REG_ROW1_C01][REG_W-1:COEF_W];
		row1[2] = regs_q[REG_ROW1_C23][COEF_W-1:0];
		row1[3] = regs_q[REG_ROW1_C23][REG_W-1:COEF_W];
		row2[0] = regs_q[REG_ROW2_C01][COEF_W-1:0];
		row2[1] = regs_q[REG_ROW2_C01][REG_W-1:COEF_W];
		row2[2] = regs_q[REG_ROW2_C23][COEF_W-1:0];
		row2[3] = regs_q[REG_ROW2_C23][REG_W-1:COEF_W];
	end

	// Advance unless a finished item is held
	assign adv      = !(vld_q[PIPE_LAT-1] && out_stall);
	assign in_stall = !adv;

	hpp_dot u_dot (
		.clk (clk),
		.en  (adv),
		.row0(row0),
		.row1(row1),
		.row2(row2),
		.x   (world_x),
		.y   (world_y),
		.z   (world_z),
		.a   (a),
		.b   (b),
		.w   (w)
	);

	hpp_div u_div_u (
		.clk(clk),
		.en (adv),
		.num(a),
		.den(w),
		.quo(u_q),
		.sat(su)
	);

	hpp_div u_div_v (
		.clk(clk),
		.en (adv),
		.num(b),
		.den(w),
		.quo(v_q),
		.sat(sv)
	);

	// Valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++)
				vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < PIPE_LAT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	// Zero-depth flag follows the divider lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_q[0] <= (w == '0);
			for (int i = 1; i < DIV_LAT; i++)
				zero_q[i] <= zero_q[i-1];
		end
	end

	assign out_valid  = vld_q[PIPE_LAT-1];
	assign zero_depth = zero_q[DIV_LAT-1];
	assign pixel_u    = zero_depth ? '0 : u_q;
	assign pixel_v    = zero_depth ? '0 : v_q;
	assign saturated  = !zero_depth && (su || sv);

`ifndef NO_ASSERTIONS
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_depth |-> pixel_u == '0 && pixel_v == '0 && !saturated)
		else $error("zero-depth item carries nonzero result");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to held output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_u) && $stable(pixel_v))
		else $error("held result changed");
`endif

endmodule
